/* hdl/fnsd_pkg.sv */
package fnsd_pkg;

    localparam int REF_W = 27;
    localparam int LO_W = 33;
    localparam int INT_W = 10;
    localparam int FRAC_BITS_DEF = 24;
    localparam int VCO_MAX_MHZ = 5400;
    localparam int CMP_W = LO_W + 7;

    localparam logic [CMP_W-1:0] VCO_MAX_HZ = CMP_W'(64'(VCO_MAX_MHZ) * 64'd1000000);
    localparam logic [LO_W-1:0] PRESC_SWITCH_HZ = 33'd3200000000;
    localparam logic [REF_W-1:0] REF_MIN_HZ = 27'd10000000;
    localparam logic [REF_W-1:0] REF_MAX_HZ = 27'd104000000;
    localparam logic [REF_W-1:0] REF_RESET_HZ = 27'd40000000;

    localparam logic [1:0] CPL_LOW = 2'd2;
    localparam logic [1:0] CPL_HIGH = 2'd3;

    typedef struct packed {
        logic       valid;
        logic       oor;
        logic [2:0] k;
        logic       p4;
    } t_ctrl;

    typedef struct packed {
        logic [2:0]      lo_div_exp;
        logic            presc_four;
        logic [1:0]      loop_coupling;
        logic [8:0]      n_integer;
        logic [15:0]     frac_high;
        logic [7:0]      frac_low;
        logic [LO_W-1:0] actual_freq_hz;
        logic            out_of_range;
        logic            last;
    } t_result;

endpackage

/* hdl/fnsd_req_if.sv */
interface fnsd_req_if import fnsd_pkg::*;;
    logic            valid;
    logic            ready;
    logic [LO_W-1:0] lo_hz;

    modport source (output valid, output lo_hz, input ready);
    modport sink (input valid, input lo_hz, output ready);
endinterface

/* hdl/fnsd_plan_if.sv */
interface fnsd_plan_if import fnsd_pkg::*;;
    logic            valid;
    logic            ready;
    logic [2:0]      lo_div_exp;
    logic            presc_four;
    logic [1:0]      loop_coupling;
    logic [8:0]      n_integer;
    logic [15:0]     frac_high;
    logic [7:0]      frac_low;
    logic [LO_W-1:0] actual_freq_hz;
    logic            out_of_range;
    logic            last;

    modport source (output valid, output lo_div_exp, output presc_four, output loop_coupling,
                    output n_integer, output frac_high, output frac_low,
                    output actual_freq_hz, output out_of_range, output last, input ready);
    modport sink (input valid, input lo_div_exp, input presc_four, input loop_coupling,
                  input n_integer, input frac_high, input frac_low,
                  input actual_freq_hz, input out_of_range, input last, output ready);
endinterface

/* hdl/fnsd_cell.sv */
module fnsd_cell import fnsd_pkg::*; #(
    parameter int QW = INT_W + FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [REF_W-1:0] i_ref,
    input  t_ctrl            i_ctrl,
    input  logic [REF_W-1:0] i_rem,
    input  logic [QW-1:0]    i_qd,
    output t_ctrl            o_ctrl,
    output logic [REF_W-1:0] o_rem,
    output logic [QW-1:0]    o_qd
);
    logic [REF_W:0]   w_t;
    logic [REF_W:0]   w_diff;
    logic             w_ge;
    logic [REF_W-1:0] n_rem;
    t_ctrl            r_ctrl;
    logic [REF_W-1:0] r_rem;
    logic [QW-1:0]    r_qd;

    assign w_t = {i_rem, i_qd[QW-1]};
    assign w_diff = w_t - {1'b0, i_ref};
    assign w_ge = w_t >= {1'b0, i_ref};
    assign n_rem = w_ge ? w_diff[REF_W-1:0] : w_t[REF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_qd <= {i_qd[QW-2:0], w_ge};
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_rem = r_rem;
    assign o_qd = r_qd;
endmodule

/* hdl/fnsd_finish.sv */
module fnsd_finish import fnsd_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [REF_W-1:0]           i_ref,
    input  t_ctrl                      i_ctrl,
    input  logic [INT_W+FRAC_BITS-1:0] i_quo,
    output logic                       o_valid,
    output logic                       o_two,
    output t_result                    o_first,
    output t_result                    o_second
);
    localparam int QW = INT_W + FRAC_BITS;
    localparam int LW = 17;
    localparam int HW = QW - LW;
    localparam int PW = REF_W + QW;

    logic [QW-1:0]       w_t2;
    logic [QW-1:0]       w_t4;
    t_ctrl               r_ctrl;
    logic [QW-1:0]       r_t2;
    logic [QW-1:0]       r_t4;
    logic [REF_W+LW-1:0] r_lo2;
    logic [REF_W+LW-1:0] r_lo4;
    logic [REF_W+HW-1:0] r_hi2;
    logic [REF_W+HW-1:0] r_hi4;
    logic [PW-1:0]       w_p2;
    logic [PW-1:0]       w_p4;
    logic [5:0]          w_sh2;
    logic [5:0]          w_sh4;
    logic [23:0]         w_f2;
    logic [23:0]         w_f4;
    t_result             w_plan2;
    t_result             w_plan4;
    t_result             n_first;
    t_result             n_second;
    logic                r_valid;
    logic                r_two;
    t_result             r_first;
    t_result             r_second;

    assign w_t2 = {1'b0, i_quo[QW-1:1]} + QW'(i_quo[0]);
    assign w_t4 = {2'b00, i_quo[QW-1:2]} + QW'(i_quo[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t2 <= w_t2;
            r_t4 <= w_t4;
            r_lo2 <= (REF_W+LW)'(i_ref) * (REF_W+LW)'(w_t2[LW-1:0]);
            r_lo4 <= (REF_W+LW)'(i_ref) * (REF_W+LW)'(w_t4[LW-1:0]);
            r_hi2 <= (REF_W+HW)'(i_ref) * (REF_W+HW)'(w_t2[QW-1:LW]);
            r_hi4 <= (REF_W+HW)'(i_ref) * (REF_W+HW)'(w_t4[QW-1:LW]);
        end
    end

    assign w_p2 = PW'(r_lo2) + (PW'(r_hi2) << LW);
    assign w_p4 = PW'(r_lo4) + (PW'(r_hi4) << LW);
    assign w_sh2 = 6'(FRAC_BITS - 1) + 6'(r_ctrl.k);
    assign w_sh4 = 6'(FRAC_BITS - 2) + 6'(r_ctrl.k);

    generate
        if (FRAC_BITS >= 24) begin : g_frac_cut
            assign w_f2 = r_t2[FRAC_BITS-1 -: 24];
            assign w_f4 = r_t4[FRAC_BITS-1 -: 24];
        end else begin : g_frac_pad
            assign w_f2 = {r_t2[FRAC_BITS-1:0], (24-FRAC_BITS)'(0)};
            assign w_f4 = {r_t4[FRAC_BITS-1:0], (24-FRAC_BITS)'(0)};
        end
    endgenerate

    always_comb begin
        w_plan2 = '0;
        w_plan2.lo_div_exp = r_ctrl.k;
        w_plan2.loop_coupling = r_ctrl.p4 ? CPL_HIGH : CPL_LOW;
        w_plan2.n_integer = r_t2[FRAC_BITS+8:FRAC_BITS];
        w_plan2.frac_high = w_f2[23:8];
        w_plan2.frac_low = w_f2[7:0];
        w_plan2.actual_freq_hz = LO_W'(w_p2 >> w_sh2);
        w_plan2.last = 1'b1;
        w_plan4 = '0;
        w_plan4.lo_div_exp = r_ctrl.k;
        w_plan4.presc_four = 1'b1;
        w_plan4.loop_coupling = CPL_HIGH;
        w_plan4.n_integer = r_t4[FRAC_BITS+8:FRAC_BITS];
        w_plan4.frac_high = w_f4[23:8];
        w_plan4.frac_low = w_f4[7:0];
        w_plan4.actual_freq_hz = LO_W'(w_p4 >> w_sh4);
        n_second = w_plan2;
        if (r_ctrl.oor) begin
            n_first = '0;
            n_first.out_of_range = 1'b1;
            n_first.last = 1'b1;
        end else if (r_ctrl.p4) begin
            n_first = w_plan4;
        end else begin
            n_first = w_plan2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_two <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_ctrl.valid;
            r_two <= r_ctrl.p4 && !r_ctrl.oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_first <= n_first;
            r_second <= n_second;
        end
    end

    assign o_valid = r_valid;
    assign o_two = r_two;
    assign o_first = r_first;
    assign o_second = r_second;
endmodule

/* hdl/fnsd_outbuf.sv */
module fnsd_outbuf import fnsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_two,
    input  t_result     i_first,
    input  t_result     i_second,
    output logic        o_can_take,
    fnsd_plan_if.source o_plan
);
    logic    r_v;
    logic    r_pend;
    t_result r_out;
    t_result r_b;

    assign o_can_take = !r_v || (o_plan.ready && !r_pend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
            r_pend <= 1'b0;
        end else if (i_valid && o_can_take) begin
            r_v <= 1'b1;
            r_pend <= i_two;
        end else if (r_v && o_plan.ready) begin
            if (r_pend) begin
                r_pend <= 1'b0;
            end else begin
                r_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_can_take) begin
            r_out <= i_first;
            r_b <= i_second;
        end else if (r_v && o_plan.ready && r_pend) begin
            r_out <= r_b;
        end
    end

    assign o_plan.valid = r_v;
    assign o_plan.lo_div_exp = r_out.lo_div_exp;
    assign o_plan.presc_four = r_out.presc_four;
    assign o_plan.loop_coupling = r_out.loop_coupling;
    assign o_plan.n_integer = r_out.n_integer;
    assign o_plan.frac_high = r_out.frac_high;
    assign o_plan.frac_low = r_out.frac_low;
    assign o_plan.actual_freq_hz = r_out.actual_freq_hz;
    assign o_plan.out_of_range = r_out.out_of_range;
    assign o_plan.last = r_out.last;

    a_pend_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_v) else $error("Second plan pending without a shown plan.");
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && !r_out.last |-> r_out.presc_four && r_pend)
        else $error("Non-final plan without a retune plan behind it.");
    a_retune: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && o_plan.ready && r_pend |=> r_v && r_out.last && !r_out.presc_four)
        else $error("Retune plan did not follow.");
endmodule

/* hdl/frac_n_synth_divider_plan.sv */
// One request is accepted every cycle while the output buffer can take a result; a request that
// needs the divide-by-4 prescaler yields two plans, and no new result enters the buffer until
// the second plan has been taken.
// The ratio is formed by a row of one-bit restoring divider cells, one per quotient bit.
// Synchronous active-low reset empties the pipeline and loads the reference with 40 MHz.
module frac_n_synth_divider_plan import fnsd_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [REF_W-1:0] i_cfg_wdata,
    fnsd_req_if.sink         i_req,
    fnsd_plan_if.source      o_plan
);
    localparam int QW = INT_W + FRAC_BITS;

    logic [REF_W-1:0] r_ref;
    logic             w_en;
    logic             w_can_take;
    logic             w_fin_valid;
    logic             w_fin_two;
    t_result          w_first;
    t_result          w_second;
    logic [CMP_W-1:0] w_lo;
    logic             w_oor;
    logic [2:0]       w_k;
    logic [LO_W-1:0]  w_fvco;
    t_ctrl            n_ctrl;
    t_ctrl            w_ctrl [QW+1];
    logic [REF_W-1:0] w_rem [QW+1];
    logic [QW-1:0]    w_qd [QW+1];
    t_ctrl            r_ctrl;
    logic [REF_W-1:0] r_rem;
    logic [QW-1:0]    r_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= REF_RESET_HZ;
        end else if (i_cfg_we && i_cfg_wdata >= REF_MIN_HZ && i_cfg_wdata <= REF_MAX_HZ) begin
            r_ref <= i_cfg_wdata;
        end
    end

    assign w_en = !w_fin_valid || w_can_take;
    assign i_req.ready = w_en;

    assign w_lo = CMP_W'(i_req.lo_hz);

    always_comb begin
        w_oor = (i_req.lo_hz == '0) || (w_lo > VCO_MAX_HZ) || ((w_lo << 7) < VCO_MAX_HZ);
        w_k = '0;
        for (int j = 1; j < 8; j++) begin
            if ((w_lo << j) <= VCO_MAX_HZ) begin
                w_k = 3'(j);
            end
        end
        w_fvco = w_oor ? '0 : LO_W'(w_lo << w_k);
        n_ctrl.valid = i_req.valid;
        n_ctrl.oor = w_oor;
        n_ctrl.k = w_k;
        n_ctrl.p4 = w_fvco > PRESC_SWITCH_HZ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (w_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem <= REF_W'(w_fvco[LO_W-1:INT_W]);
            r_qd <= {w_fvco[INT_W-1:0], FRAC_BITS'(0)};
        end
    end

    assign w_ctrl[0] = r_ctrl;
    assign w_rem[0] = r_rem;
    assign w_qd[0] = r_qd;

    generate
        for (genvar g = 0; g < QW; g++) begin : g_cell
            fnsd_cell #(.QW(QW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_ref   (r_ref),
                .i_ctrl  (w_ctrl[g]),
                .i_rem   (w_rem[g]),
                .i_qd    (w_qd[g]),
                .o_ctrl  (w_ctrl[g+1]),
                .o_rem   (w_rem[g+1]),
                .o_qd    (w_qd[g+1])
            );
        end
    endgenerate

    fnsd_finish #(.FRAC_BITS(FRAC_BITS)) u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ref    (r_ref),
        .i_ctrl   (w_ctrl[QW]),
        .i_quo    (w_qd[QW]),
        .o_valid  (w_fin_valid),
        .o_two    (w_fin_two),
        .o_first  (w_first),
        .o_second (w_second)
    );

    fnsd_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_fin_valid),
        .i_two      (w_fin_two),
        .i_first    (w_first),
        .i_second   (w_second),
        .o_can_take (w_can_take),
        .o_plan     (o_plan)
    );
endmodule

/* test/frac_n_synth_divider_plan_test.sv */
module frac_n_synth_divider_plan_test;
    import fnsd_pkg::*;

    localparam int FRAC = 24;
    localparam int LATENCY = FRAC + 14;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] VCO_HZ = 64'd5400000000;
    localparam logic [63:0] SWITCH_HZ = 64'd3200000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [REF_W-1:0] i_cfg_wdata;

    fnsd_req_if req_bus();
    fnsd_plan_if plan_bus();

    frac_n_synth_divider_plan DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req(req_bus.sink),
        .o_plan(plan_bus.source)
    );

    logic [63:0] ref_hz;
    logic [LO_W-1:0] pending_lo[$];
    t_result expected_plans[$];
    int failures;
    int watchdog;
    bit no_idle;
    int send_gap;
    int recv_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result divider_plan(logic [63:0] fvco, int k, logic [63:0] fbk,
                                             bit p4, bit last);
        t_result res;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] frac;
        logic [63:0] total;
        logic [63:0] fr;
        logic [63:0] a;
        logic [63:0] act;
        d = fbk * ref_hz;
        q = fvco / d;
        r = fvco % d;
        frac = 0;
        for (int i = 0; i < FRAC; i++) begin
            r = r << 1;
            frac = frac << 1;
            if (r >= d) begin
                frac = frac | 1;
                r = r - d;
            end
        end
        r = r << 1;
        total = (q << FRAC) + frac + ((r >= d) ? 64'd1 : 64'd0);
        q = total >> FRAC;
        fr = total & ((64'd1 << FRAC) - 1);
        a = ref_hz * fbk;
        act = (a * q + ((a * fr) >> FRAC)) >> k;
        res = '0;
        res.lo_div_exp = k[2:0];
        res.presc_four = p4;
        res.loop_coupling = (fvco > SWITCH_HZ) ? CPL_HIGH : CPL_LOW;
        res.n_integer = q[8:0];
        res.frac_high = fr[23:8];
        res.frac_low = fr[7:0];
        res.actual_freq_hz = act[LO_W-1:0];
        res.last = last;
        return res;
    endfunction

    task automatic predict_plans(logic [LO_W-1:0] lo_in);
        logic [63:0] lo;
        logic [63:0] fvco;
        int k;
        t_result res;
        lo = 64'(lo_in);
        if (lo == 0 || lo > VCO_HZ || lo * 128 < VCO_HZ) begin
            res = '0;
            res.out_of_range = 1'b1;
            res.last = 1'b1;
            expected_plans.push_back(res);
        end else begin
            k = 0;
            while (k < 7 && (lo << (k + 1)) <= VCO_HZ) k++;
            fvco = lo << k;
            if (fvco > SWITCH_HZ) begin
                expected_plans.push_back(divider_plan(fvco, k, 4, 1'b1, 1'b0));
                expected_plans.push_back(divider_plan(fvco, k, 2, 1'b0, 1'b1));
            end else begin
                expected_plans.push_back(divider_plan(fvco, k, 2, 1'b0, 1'b1));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                predict_plans(req_bus.lo_hz);
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (send_gap > 0) begin
                    req_bus.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_lo.size() > 0) begin
                    req_bus.valid <= 1'b1;
                    req_bus.lo_hz <= pending_lo.pop_front();
                    if (!no_idle && $urandom_range(0, 9) == 0) begin
                        send_gap <= $urandom_range(1, 12);
                    end
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            plan_bus.ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (plan_bus.valid && plan_bus.ready) begin
                if (expected_plans.size() == 0) begin
                    $display("%0t: unexpected plan %p", $time, plan_bus.lo_div_exp);
                    failures++;
                end else begin
                    t_result want;
                    t_result got;
                    want = expected_plans.pop_front();
                    got.lo_div_exp = plan_bus.lo_div_exp;
                    got.presc_four = plan_bus.presc_four;
                    got.loop_coupling = plan_bus.loop_coupling;
                    got.n_integer = plan_bus.n_integer;
                    got.frac_high = plan_bus.frac_high;
                    got.frac_low = plan_bus.frac_low;
                    got.actual_freq_hz = plan_bus.actual_freq_hz;
                    got.out_of_range = plan_bus.out_of_range;
                    got.last = plan_bus.last;
                    if (got !== want) begin
                        $display("%0t: plan mismatch expected %p actual %p", $time, want, got);
                        failures++;
                    end
                end
            end
            if (recv_gap > 0) begin
                plan_bus.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                plan_bus.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0) begin
                    recv_gap <= $urandom_range(1, 12);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) ||
                (plan_bus.valid && plan_bus.ready)) begin
            watchdog <= 0;
        end else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    function automatic logic [LO_W-1:0] random_lo();
        logic [63:0] lo;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            lo = {$urandom, $urandom};
            return lo[LO_W-1:0];
        end else if (pick == 1) begin
            return LO_W'($urandom_range(0, 42187500));
        end else if (pick == 2) begin
            return LO_W'(64'd5400000000 - $urandom_range(0, 1000));
        end
        lo = 64'd42187500 + ((64'($urandom) << 1) | $urandom_range(0, 1)) % 64'd5357812501;
        return lo[LO_W-1:0];
    endfunction

    task automatic write_ref(logic [REF_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (value >= REF_MIN_HZ && value <= REF_MAX_HZ) ref_hz = 64'(value);
    endtask

    task automatic run_phase(int count);
        for (int i = 0; i < count; i++) pending_lo.push_back(random_lo());
        wait (pending_lo.size() == 0 && !req_bus.valid && expected_plans.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        wait (expected_plans.size() == 0);
    endtask

    initial begin
        logic [LO_W-1:0] directed[$];
        failures = 0;
        no_idle = 1'b0;
        ref_hz = 64'(REF_RESET_HZ);
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_bus.valid = 1'b0;
        req_bus.lo_hz = '0;
        plan_bus.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{33'd0, 33'd1, 33'h1FFFFFFFF, 33'd5400000000, 33'd5400000001,
                     33'd42187500, 33'd42187499, 33'd3200000000, 33'd3200000001,
                     33'd2700000000, 33'd2700000001, 33'd100000000, 33'd915000000,
                     33'd433920000, 33'd1600000001, 33'd4294967296, 33'd5399999999};
        foreach (directed[i]) pending_lo.push_back(directed[i]);
        run_phase(200);

        write_ref(27'd10000000);
        run_phase(300);
        write_ref(27'd104000000);
        run_phase(300);
        write_ref(27'd9999999);
        write_ref(27'd104000001);
        write_ref(27'h7FFFFFF);
        run_phase(200);
        write_ref(27'd26000000);
        run_phase(300);
        write_ref(REF_W'($urandom_range(10000000, 104000000)));
        run_phase(300);
        write_ref(27'd40000000);
        no_idle = 1'b1;
        run_phase(330);

        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
